FILE: rtl/tbc_pkg.sv
// Shared widths, stage counts and sideband type for the two-body collision pipeline.
// Used by every module of the block; depends on nothing.
package tbc_pkg;

	localparam int WORD_W      = 32;
	localparam int REST_W      = 17;
	localparam logic [REST_W-1:0] REST_RESET = 17'd64881;
	localparam int REST_FRAC   = 16;
	localparam int GUARD       = 8;
	localparam int MIX_FRAC    = 32;
	localparam int FINAL_SHIFT = MIX_FRAC + REST_FRAC + GUARD;

	// Differences of two words, their products and sums.
	localparam int DIF_W  = WORD_W + 1;
	localparam int PRD_W  = 2 * DIF_W;
	localparam int DOT_W  = PRD_W + 1;
	localparam int MAGD_W = PRD_W;
	localparam int R2_W   = PRD_W;
	localparam int HALF_W = MAGD_W / 2;

	// Widths of the restoring dividers for the projections and the mass weight.
	localparam int DIV_NW = 108;
	localparam int DIV_DW = R2_W + 1;
	localparam int DIV_QW = 42;

	// Mixing datapath.
	localparam int MIX_W  = MIX_FRAC + 1;
	localparam int Q2_W   = 44;
	localparam int EQ_W   = Q2_W + REST_W + 1;
	localparam int T_W    = EQ_W + 1;
	localparam int TLO_W  = 31;
	localparam int THI_W  = T_W - TLO_W;
	localparam int LO_W   = MIX_W + TLO_W;
	localparam int HI_W   = MIX_W + 1 + THI_W;
	localparam int PROD_W = HI_W + TLO_W;
	localparam int DEL_W  = PROD_W - FINAL_SHIFT;
	localparam int SUM_W  = DEL_W + 1;

	localparam int GEOM_STAGES = 5;
	localparam int DIV_STAGES  = DIV_QW;
	localparam int MIX_STAGES  = 6;
	localparam int PIPE_STAGES = GEOM_STAGES + DIV_STAGES + MIX_STAGES;

	localparam int N_LANES = 4;

	typedef struct packed {
		logic signed [WORD_W-1:0] va_x;
		logic signed [WORD_W-1:0] va_y;
		logic signed [WORD_W-1:0] vb_x;
		logic signed [WORD_W-1:0] vb_y;
		logic signed [DIF_W-1:0]  u_x;
		logic signed [DIF_W-1:0]  u_y;
		logic                     neg_x;
		logic                     neg_y;
		logic                     pass;
	} side_t;

	typedef struct packed {
		logic [WORD_W-1:0] vel_ax;
		logic [WORD_W-1:0] vel_ay;
		logic [WORD_W-1:0] vel_bx;
		logic [WORD_W-1:0] vel_by;
		logic              applied;
		logic              saturated;
	} result_t;

endpackage

FILE: rtl/tbc_div.sv
// Pipelined restoring divider, one quotient bit per stage, no sideband.
// Depends on tbc_pkg; stage enables come from the pipeline control in the top level.
module tbc_div import tbc_pkg::*; (
	input  logic                  clk,
	input  logic [DIV_STAGES-1:0] en,
	input  logic [DIV_NW-1:0]     num,
	input  logic [DIV_DW-1:0]     den,
	output logic [DIV_QW-1:0]     quo
);

	logic [DIV_DW-1:0] rem_s [DIV_STAGES];
	logic [DIV_QW-1:0] nq_s  [DIV_STAGES];
	logic [DIV_DW-1:0] den_s [DIV_STAGES];

	logic [DIV_DW-1:0] rem_in [DIV_STAGES];
	logic [DIV_QW-1:0] nq_in  [DIV_STAGES];
	logic [DIV_DW-1:0] den_in [DIV_STAGES];
	logic [DIV_DW-1:0] rem_nx [DIV_STAGES];
	logic [DIV_QW-1:0] nq_nx  [DIV_STAGES];

	// The upper numerator bits seed the remainder; the rest shift in one per stage
	// while the quotient bits shift into the same register from below.
	assign rem_in[0] = DIV_DW'(num[DIV_NW-1:DIV_QW]);
	assign nq_in[0]  = num[DIV_QW-1:0];
	assign den_in[0] = den;

	for (genvar k = 1; k < DIV_STAGES; k++) begin : g_link
		assign rem_in[k] = rem_s[k-1];
		assign nq_in[k]  = nq_s[k-1];
		assign den_in[k] = den_s[k-1];
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic [DIV_DW:0] trial;
		logic [DIV_DW:0] diff;
		logic            take;

		always_comb begin
			trial     = {rem_in[k], nq_in[k][DIV_QW-1]};
			diff      = trial - {1'b0, den_in[k]};
			take      = (trial >= {1'b0, den_in[k]});
			rem_nx[k] = take ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			nq_nx[k]  = {nq_in[k][DIV_QW-2:0], take};
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= rem_nx[k];
				nq_s[k]  <= nq_nx[k];
				den_s[k] <= den_in[k];
			end
		end
	end

	assign quo = nq_s[DIV_STAGES-1];

endmodule

FILE: rtl/tbc_geom.sv
// Front stages: separation, relative velocity, dot products and the divider operands.
// Depends on tbc_pkg; stage enables come from the pipeline control in the top level.
module tbc_geom import tbc_pkg::*; (
	input  logic                   clk,
	input  logic [GEOM_STAGES-1:0] en,
	input  logic                   touching,
	input  logic [WORD_W-1:0]      mass_a,
	input  logic [WORD_W-1:0]      mass_b,
	input  logic [WORD_W-1:0]      pos_ax,
	input  logic [WORD_W-1:0]      pos_ay,
	input  logic [WORD_W-1:0]      pos_bx,
	input  logic [WORD_W-1:0]      pos_by,
	input  logic [WORD_W-1:0]      vel_ax,
	input  logic [WORD_W-1:0]      vel_ay,
	input  logic [WORD_W-1:0]      vel_bx,
	input  logic [WORD_W-1:0]      vel_by,
	output logic [DIV_NW-1:0]      num_x,
	output logic [DIV_NW-1:0]      num_y,
	output logic [DIV_DW-1:0]      den,
	output logic [DIV_NW-1:0]      wnum,
	output logic [DIV_DW-1:0]      wden,
	output side_t                  side
);

	// Stage 1
	logic signed [DIF_W-1:0] r_x_s1, r_y_s1;
	logic [WORD_W-1:0]       ma_s1, mb_s1;
	logic                    touch_s1;
	side_t                   side_s1;
	// Stage 2
	logic signed [PRD_W-1:0] ru_x_s2, ru_y_s2;
	logic [R2_W-1:0]         sq_x_s2, sq_y_s2;
	logic [DIF_W-1:0]        rabs_x_s2, rabs_y_s2;
	logic [DIF_W-1:0]        m_s2;
	logic [WORD_W-1:0]       mb_s2;
	logic                    touch_s2;
	side_t                   side_s2;
	// Stage 3
	logic [MAGD_W-1:0]       magd_s3;
	logic [R2_W-1:0]         r2_s3;
	logic [DIF_W-1:0]        rabs_x_s3, rabs_y_s3;
	logic [WORD_W+DIF_W-1:0] wnum_s3;
	logic [DIF_W-1:0]        wden_s3;
	side_t                   side_s3;
	// Stage 4
	logic [PRD_W-1:0]        pl_x_s4, ph_x_s4, pl_y_s4, ph_y_s4;
	logic [R2_W-1:0]         r2_s4;
	logic [WORD_W+DIF_W-1:0] wnum_s4;
	logic [DIF_W-1:0]        wden_s4;
	side_t                   side_s4;
	// Stage 5
	logic [DIV_NW-1:0]       num_x_s5, num_y_s5, wnum_s5;
	logic [DIV_DW-1:0]       den_s5, wden_s5;
	side_t                   side_s5;

	logic signed [DIF_W-1:0] r_x_c, r_y_c, u_x_c, u_y_c;
	logic [DIF_W-1:0]        rabs_x_c, rabs_y_c;
	logic signed [DOT_W-1:0] dot_c;
	logic [DOT_W-1:0]        ndot_c;
	logic [R2_W-1:0]         r2_c;

	always_comb begin
		r_x_c    = $signed({pos_bx[WORD_W-1], pos_bx}) - $signed({pos_ax[WORD_W-1], pos_ax});
		r_y_c    = $signed({pos_by[WORD_W-1], pos_by}) - $signed({pos_ay[WORD_W-1], pos_ay});
		u_x_c    = $signed({vel_bx[WORD_W-1], vel_bx}) - $signed({vel_ax[WORD_W-1], vel_ax});
		u_y_c    = $signed({vel_by[WORD_W-1], vel_by}) - $signed({vel_ay[WORD_W-1], vel_ay});
		rabs_x_c = r_x_s1[DIF_W-1] ? DIF_W'(-r_x_s1) : DIF_W'(r_x_s1);
		rabs_y_c = r_y_s1[DIF_W-1] ? DIF_W'(-r_y_s1) : DIF_W'(r_y_s1);
		dot_c    = $signed({ru_x_s2[PRD_W-1], ru_x_s2}) + $signed({ru_y_s2[PRD_W-1], ru_y_s2});
		ndot_c   = DOT_W'(-dot_c);
		r2_c     = sq_x_s2 + sq_y_s2;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			r_x_s1        <= r_x_c;
			r_y_s1        <= r_y_c;
			ma_s1         <= mass_a;
			mb_s1         <= mass_b;
			touch_s1      <= touching;
			side_s1.va_x  <= $signed(vel_ax);
			side_s1.va_y  <= $signed(vel_ay);
			side_s1.vb_x  <= $signed(vel_bx);
			side_s1.vb_y  <= $signed(vel_by);
			side_s1.u_x   <= u_x_c;
			side_s1.u_y   <= u_y_c;
			// A positive separation component flips the sign of its projection.
			side_s1.neg_x <= !r_x_c[DIF_W-1] && (r_x_c != '0);
			side_s1.neg_y <= !r_y_c[DIF_W-1] && (r_y_c != '0);
			side_s1.pass  <= 1'b0;
		end
		if (en[1]) begin
			ru_x_s2   <= PRD_W'(r_x_s1) * PRD_W'(side_s1.u_x);
			ru_y_s2   <= PRD_W'(r_y_s1) * PRD_W'(side_s1.u_y);
			sq_x_s2   <= R2_W'(rabs_x_c) * R2_W'(rabs_x_c);
			sq_y_s2   <= R2_W'(rabs_y_c) * R2_W'(rabs_y_c);
			rabs_x_s2 <= rabs_x_c;
			rabs_y_s2 <= rabs_y_c;
			m_s2      <= DIF_W'(ma_s1) + DIF_W'(mb_s1);
			mb_s2     <= mb_s1;
			touch_s2  <= touch_s1;
			side_s2   <= side_s1;
		end
		if (en[2]) begin
			magd_s3      <= ndot_c[MAGD_W-1:0];
			r2_s3        <= r2_c;
			rabs_x_s3    <= rabs_x_s2;
			rabs_y_s3    <= rabs_y_s2;
			wnum_s3      <= {1'b0, mb_s2, {MIX_FRAC{1'b0}}} + (WORD_W+DIF_W)'(m_s2 >> 1);
			wden_s3      <= m_s2;
			// The response applies only to touching, approaching pairs with a second mass.
			side_s3      <= {side_s2[$bits(side_t)-1:1],
				touch_s2 && (mb_s2 != '0) && dot_c[DOT_W-1]};
		end
		if (en[3]) begin
			pl_x_s4 <= PRD_W'(magd_s3[HALF_W-1:0]) * PRD_W'(rabs_x_s3);
			ph_x_s4 <= PRD_W'(magd_s3[MAGD_W-1:HALF_W]) * PRD_W'(rabs_x_s3);
			pl_y_s4 <= PRD_W'(magd_s3[HALF_W-1:0]) * PRD_W'(rabs_y_s3);
			ph_y_s4 <= PRD_W'(magd_s3[MAGD_W-1:HALF_W]) * PRD_W'(rabs_y_s3);
			r2_s4   <= r2_s3;
			wnum_s4 <= wnum_s3;
			wden_s4 <= wden_s3;
			side_s4 <= side_s3;
		end
		if (en[4]) begin
			num_x_s5 <= (DIV_NW'(ph_x_s4) << (HALF_W + GUARD + 1))
				+ (DIV_NW'(pl_x_s4) << (GUARD + 1)) + DIV_NW'(r2_s4);
			num_y_s5 <= (DIV_NW'(ph_y_s4) << (HALF_W + GUARD + 1))
				+ (DIV_NW'(pl_y_s4) << (GUARD + 1)) + DIV_NW'(r2_s4);
			den_s5   <= {r2_s4, 1'b0};
			wnum_s5  <= DIV_NW'(wnum_s4);
			wden_s5  <= DIV_DW'(wden_s4);
			side_s5  <= side_s4;
		end
	end

	assign num_x = num_x_s5;
	assign num_y = num_y_s5;
	assign den   = den_s5;
	assign wnum  = wnum_s5;
	assign wden  = wden_s5;
	assign side  = side_s5;

endmodule

FILE: rtl/tbc_mix.sv
// Back stages: restitution blend, mass weighting, rounding and saturation of the velocities.
// Depends on tbc_pkg; stage enables come from the pipeline control in the top level.
module tbc_mix import tbc_pkg::*; (
	input  logic                  clk,
	input  logic [MIX_STAGES-1:0] en,
	input  logic [DIV_QW-1:0]     quo_x,
	input  logic [DIV_QW-1:0]     quo_y,
	input  logic [DIV_QW-1:0]     quo_w,
	input  side_t                 side,
	input  logic [REST_W-1:0]     restitution,
	output result_t               result
);

	localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) <<< (FINAL_SHIFT - 1);
	localparam logic [MIX_W-1:0]         ONE  = MIX_W'(1) << MIX_FRAC;

	logic signed [Q2_W-1:0]   q2_s6 [2];
	logic [MIX_W-1:0]         wa_s6, wb_s6;
	side_t                    side_s6;
	logic signed [EQ_W-1:0]   eq_s7 [2];
	logic [MIX_W-1:0]         wa_s7, wb_s7;
	side_t                    side_s7;
	logic signed [T_W-1:0]    t_s8 [2];
	logic [MIX_W-1:0]         wa_s8, wb_s8;
	side_t                    side_s8;
	logic [LO_W-1:0]          plo_s9 [N_LANES];
	logic signed [HI_W-1:0]   phi_s9 [N_LANES];
	side_t                    side_s9;
	logic signed [DEL_W-1:0]  del_s10 [N_LANES];
	side_t                    side_s10;
	logic [WORD_W-1:0]        vel_s11 [N_LANES];
	logic                     applied_s11, sat_s11;

	logic signed [Q2_W-1:0]   p_c [2];
	logic [MIX_W-1:0]         wa_c;
	logic signed [Q2_W-1:0]   q2_c [2];
	logic signed [PROD_W-1:0] pw_c [N_LANES];
	logic signed [WORD_W-1:0] base_c [N_LANES];
	logic signed [SUM_W-1:0]  sum_c [N_LANES];
	logic [WORD_W-1:0]        vsat_c [N_LANES];
	logic [N_LANES-1:0]       clip_c;

	function automatic logic [WORD_W-1:0] clamp(input logic signed [SUM_W-1:0] v);
		logic [WORD_W-1:0] r;
		if (v[SUM_W-1] == 1'b0 && v[SUM_W-2:WORD_W-1] != '0) begin
			r = {1'b0, {(WORD_W-1){1'b1}}};
		end else if (v[SUM_W-1] == 1'b1 && v[SUM_W-2:WORD_W-1] != '1) begin
			r = {1'b1, {(WORD_W-1){1'b0}}};
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

	always_comb begin
		wa_c    = quo_w[MIX_W-1:0];
		p_c[0]  = side.neg_x ? -$signed(Q2_W'(quo_x)) : $signed(Q2_W'(quo_x));
		p_c[1]  = side.neg_y ? -$signed(Q2_W'(quo_y)) : $signed(Q2_W'(quo_y));
		q2_c[0] = (p_c[0] <<< 1) - (Q2_W'(side.u_x) <<< GUARD);
		q2_c[1] = (p_c[1] <<< 1) - (Q2_W'(side.u_y) <<< GUARD);
		base_c[0] = side_s10.va_x;
		base_c[1] = side_s10.va_y;
		base_c[2] = side_s10.vb_x;
		base_c[3] = side_s10.vb_y;
		for (int l = 0; l < N_LANES; l++) begin
			pw_c[l]   = (PROD_W'(phi_s9[l]) <<< TLO_W) + $signed(PROD_W'(plo_s9[l])) + HALF;
			// The first body gains its share of the impulse and the second loses its own.
			sum_c[l]  = (l < 2) ? SUM_W'(base_c[l]) + SUM_W'(del_s10[l])
				: SUM_W'(base_c[l]) - SUM_W'(del_s10[l]);
			vsat_c[l] = clamp(sum_c[l]);
			clip_c[l] = (sum_c[l][SUM_W-1:WORD_W-1] != '0) && (sum_c[l][SUM_W-1:WORD_W-1] != '1);
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			q2_s6   <= q2_c;
			wa_s6   <= wa_c;
			wb_s6   <= ONE - wa_c;
			side_s6 <= side;
		end
		if (en[1]) begin
			for (int a = 0; a < 2; a++) begin
				eq_s7[a] <= EQ_W'($signed({1'b0, restitution})) * EQ_W'(q2_s6[a]);
			end
			wa_s7   <= wa_s6;
			wb_s7   <= wb_s6;
			side_s7 <= side_s6;
		end
		if (en[2]) begin
			t_s8[0] <= (T_W'(side_s7.u_x) <<< (GUARD + REST_FRAC)) + T_W'(eq_s7[0]);
			t_s8[1] <= (T_W'(side_s7.u_y) <<< (GUARD + REST_FRAC)) + T_W'(eq_s7[1]);
			wa_s8   <= wa_s7;
			wb_s8   <= wb_s7;
			side_s8 <= side_s7;
		end
		if (en[3]) begin
			for (int l = 0; l < N_LANES; l++) begin
				plo_s9[l] <= LO_W'((l < 2) ? wa_s8 : wb_s8) * LO_W'(t_s8[l % 2][TLO_W-1:0]);
				phi_s9[l] <= HI_W'($signed({1'b0, ((l < 2) ? wa_s8 : wb_s8)}))
					* HI_W'($signed(t_s8[l % 2][T_W-1:TLO_W]));
			end
			side_s9 <= side_s8;
		end
		if (en[4]) begin
			for (int l = 0; l < N_LANES; l++) begin
				del_s10[l] <= pw_c[l][PROD_W-1:FINAL_SHIFT];
			end
			side_s10 <= side_s9;
		end
		if (en[5]) begin
			for (int l = 0; l < N_LANES; l++) begin
				vel_s11[l] <= side_s10.pass ? vsat_c[l] : base_c[l];
			end
			applied_s11 <= side_s10.pass;
			sat_s11     <= side_s10.pass && (clip_c != '0);
		end
	end

	assign result.vel_ax    = vel_s11[0];
	assign result.vel_ay    = vel_s11[1];
	assign result.vel_bx    = vel_s11[2];
	assign result.vel_by    = vel_s11[3];
	assign result.applied   = applied_s11;
	assign result.saturated = sat_s11;

endmodule

FILE: rtl/two_body_collision_response_2d.sv
// Two-body 2D collision response: top level with stream ports, pipeline control
// and the restitution register. Depends on tbc_pkg, tbc_geom, tbc_div and tbc_mix.
//
// Usage: one body pair per input word on the s_ group, one result word per pair on
// the m_ group, in order. The restitution register (unsigned Q1.16) is written on
// the cfg_ channel, which is always ready; write it only while the pipeline is empty.
// There are 5 front stages (differences, dot products, operand setup), 42 divider
// stages (one quotient bit each, three dividers side by side) and 6 blend stages.
// Throughput is one pair per cycle while the receiver holds m_tready high.
// Every stage holds a valid bit; a stage advances when it is empty or the stage
// after it advances, so a stalled receiver stops only the words behind the held
// result and bubbles are squeezed out. While m_tready is high s_tready is high.
// Reset empties the pipeline and loads restitution with 64881 (about 0.99).
module two_body_collision_response_2d import tbc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// mass_a, mass_b, pos_ax, pos_ay, pos_bx, pos_by, vel_ax, vel_ay, vel_bx, vel_by
	input  logic [10*WORD_W-1:0] s_tdata,
	// touching
	input  logic                s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	// new_vel_ax, new_vel_ay, new_vel_bx, new_vel_by
	output logic [4*WORD_W-1:0] m_tdata,
	// applied, saturated
	output logic [1:0]          m_tuser,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [REST_W-1:0]   cfg_data
);

	localparam int LAST = PIPE_STAGES - 1;

	logic [REST_W-1:0]      restitution_q;
	logic                   vld_s [PIPE_STAGES];
	logic [PIPE_STAGES-1:0] en;

	logic [DIV_NW-1:0] num_x, num_y, wnum;
	logic [DIV_DW-1:0] den, wden;
	logic [DIV_QW-1:0] quo_x, quo_y, quo_w;
	side_t             side_geom;
	side_t             side_dv_s [DIV_STAGES];
	result_t           result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restitution_q <= REST_RESET;
		end else if (cfg_valid && cfg_ready) begin
			restitution_q <= cfg_data;
		end
	end

	always_comb begin
		en[LAST] = !vld_s[LAST] || m_tready;
		for (int k = LAST - 1; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < PIPE_STAGES; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			if (en[0]) begin
				vld_s[0] <= s_tvalid;
			end
			for (int k = 1; k < PIPE_STAGES; k++) begin
				if (en[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	assign s_tready = en[0];
	assign m_tvalid = vld_s[LAST];

	tbc_geom u_geom (
		.clk      (clk),
		.en       (en[GEOM_STAGES-1:0]),
		.touching (s_tuser),
		.mass_a   (s_tdata[0*WORD_W +: WORD_W]),
		.mass_b   (s_tdata[1*WORD_W +: WORD_W]),
		.pos_ax   (s_tdata[2*WORD_W +: WORD_W]),
		.pos_ay   (s_tdata[3*WORD_W +: WORD_W]),
		.pos_bx   (s_tdata[4*WORD_W +: WORD_W]),
		.pos_by   (s_tdata[5*WORD_W +: WORD_W]),
		.vel_ax   (s_tdata[6*WORD_W +: WORD_W]),
		.vel_ay   (s_tdata[7*WORD_W +: WORD_W]),
		.vel_bx   (s_tdata[8*WORD_W +: WORD_W]),
		.vel_by   (s_tdata[9*WORD_W +: WORD_W]),
		.num_x    (num_x),
		.num_y    (num_y),
		.den      (den),
		.wnum     (wnum),
		.wden     (wden),
		.side     (side_geom)
	);

	tbc_div u_div_x (
		.clk (clk),
		.en  (en[GEOM_STAGES +: DIV_STAGES]),
		.num (num_x),
		.den (den),
		.quo (quo_x)
	);

	tbc_div u_div_y (
		.clk (clk),
		.en  (en[GEOM_STAGES +: DIV_STAGES]),
		.num (num_y),
		.den (den),
		.quo (quo_y)
	);

	tbc_div u_div_w (
		.clk (clk),
		.en  (en[GEOM_STAGES +: DIV_STAGES]),
		.num (wnum),
		.den (wden),
		.quo (quo_w)
	);

	// Velocities and flags ride alongside the dividers.
	always_ff @(posedge clk) begin
		if (en[GEOM_STAGES]) begin
			side_dv_s[0] <= side_geom;
		end
		for (int k = 1; k < DIV_STAGES; k++) begin
			if (en[GEOM_STAGES+k]) begin
				side_dv_s[k] <= side_dv_s[k-1];
			end
		end
	end

	tbc_mix u_mix (
		.clk         (clk),
		.en          (en[GEOM_STAGES+DIV_STAGES +: MIX_STAGES]),
		.quo_x       (quo_x),
		.quo_y       (quo_y),
		.quo_w       (quo_w),
		.side        (side_dv_s[DIV_STAGES-1]),
		.restitution (restitution_q),
		.result      (result)
	);

	assign m_tdata = {result.vel_by, result.vel_bx, result.vel_ay, result.vel_ax};
	assign m_tuser = {result.saturated, result.applied};

	// A pass-through word never reports a clamped value.
	a_sat_needs_apply: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> !m_tuser[1])
		else $error("saturated set on a word that was not applied");

	// A ready receiver lets every stage advance, so the input side is open too.
	a_ready_through: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |-> s_tready)
		else $error("input stalled while output was ready");

	// An empty first stage always takes a new word.
	a_bubble_accept: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s[0] |-> s_tready)
		else $error("input stalled with an empty first stage");

	// A held result stays valid until it is taken.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[LAST] && !m_tready |=> vld_s[LAST] && $stable(result))
		else $error("held result word changed or vanished");

	// A configuration write lands in the register.
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> restitution_q == $past(cfg_data))
		else $error("restitution write lost");

endmodule

FILE: tb/sv/tb_two_body_collision_response_2d.sv
// Self-checking testbench for the two-body 2D collision response pipeline.
// A scoreboard class predicts each result word from the accepted input word.
// Depends on tbc_pkg and two_body_collision_response_2d.
module tb_two_body_collision_response_2d;
	timeunit 1ns;
	timeprecision 1ps;
	import tbc_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int PHASE_ITEMS = 130;
	localparam int APPLIED_BIT = 0;
	localparam int SAT_BIT     = 1;
	localparam logic [REST_W-1:0] REST_ELASTIC = 17'd65536;
	localparam logic [REST_W-1:0] REST_MAX     = 17'h1FFFF;

	typedef struct {
		logic              touching;
		logic [WORD_W-1:0] mass_a, mass_b;
		logic [WORD_W-1:0] pos_ax, pos_ay, pos_bx, pos_by;
		logic [WORD_W-1:0] vel_ax, vel_ay, vel_bx, vel_by;
	} pair_t;

	class collision_scoreboard;
		result_t     expected_q[$];
		logic [REST_W-1:0] restitution = REST_RESET;
		int          mismatches = 0;

		function logic signed [127:0] wide(logic signed [WORD_W-1:0] x);
			return x;
		endfunction

		function logic [WORD_W-1:0] clamp(logic signed [127:0] v, ref logic flag);
			logic signed [127:0] hi, lo;
			hi = (128'sd1 <<< (WORD_W - 1)) - 1;
			lo = -hi - 1;
			if (v > hi) begin
				v = hi;
				flag = 1'b1;
			end
			if (v < lo) begin
				v = lo;
				flag = 1'b1;
			end
			return v[WORD_W-1:0];
		endfunction

		// Elastic exchange along the line of centers, then restitution blend.
		function void note_pair(pair_t p);
			logic signed [127:0] va[2], vb[2], r[2], u[2];
			logic signed [127:0] d, magd, r2, m, wa, wb, c, n, quo, proj, q2, t, e, half;
			logic flag;
			result_t res;
			va[0] = wide(p.vel_ax); va[1] = wide(p.vel_ay);
			vb[0] = wide(p.vel_bx); vb[1] = wide(p.vel_by);
			r[0] = wide(p.pos_bx) - wide(p.pos_ax);
			r[1] = wide(p.pos_by) - wide(p.pos_ay);
			u[0] = vb[0] - va[0];
			u[1] = vb[1] - va[1];
			d = r[0] * u[0] + r[1] * u[1];
			flag = 1'b0;
			if (!p.touching || p.mass_b == 0 || d >= 0) begin
				res.vel_ax = p.vel_ax; res.vel_ay = p.vel_ay;
				res.vel_bx = p.vel_bx; res.vel_by = p.vel_by;
				res.applied = 1'b0;
				res.saturated = 1'b0;
			end else begin
				magd = -d;
				r2 = r[0] * r[0] + r[1] * r[1];
				m = $signed({96'b0, p.mass_a}) + $signed({96'b0, p.mass_b});
				wa = (($signed({96'b0, p.mass_b}) <<< MIX_FRAC) + (m >>> 1)) / m;
				wb = (128'sd1 <<< MIX_FRAC) - wa;
				e = $signed({111'b0, restitution});
				half = 128'sd1 <<< (FINAL_SHIFT - 1);
				for (int k = 0; k < 2; k++) begin
					c = r[k];
					n = (magd * (c < 0 ? -c : c)) <<< (GUARD + 1);
					quo = (n + r2) / (r2 <<< 1);
					proj = (c > 0) ? -quo : quo;
					q2 = 2 * proj - u[k] * (128'sd1 <<< GUARD);
					t = u[k] * (128'sd1 <<< (GUARD + REST_FRAC)) + e * q2;
					if (k == 0) begin
						res.vel_ax = clamp(va[0] + ((wa * t + half) >>> FINAL_SHIFT), flag);
						res.vel_bx = clamp(vb[0] - ((wb * t + half) >>> FINAL_SHIFT), flag);
					end else begin
						res.vel_ay = clamp(va[1] + ((wa * t + half) >>> FINAL_SHIFT), flag);
						res.vel_by = clamp(vb[1] - ((wb * t + half) >>> FINAL_SHIFT), flag);
					end
				end
				res.applied = 1'b1;
				res.saturated = flag;
			end
			expected_q.push_back(res);
		endfunction

		function void check_word(logic [4*WORD_W-1:0] data, logic [1:0] user);
			result_t exp_r;
			result_t got;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: result word with nothing expected: %h", data);
				return;
			end
			exp_r = expected_q.pop_front();
			got.vel_ax = data[0*WORD_W +: WORD_W];
			got.vel_ay = data[1*WORD_W +: WORD_W];
			got.vel_bx = data[2*WORD_W +: WORD_W];
			got.vel_by = data[3*WORD_W +: WORD_W];
			got.applied = user[APPLIED_BIT];
			got.saturated = user[SAT_BIT];
			if (got.vel_ax != exp_r.vel_ax || got.vel_ay != exp_r.vel_ay ||
					got.vel_bx != exp_r.vel_bx || got.vel_by != exp_r.vel_by ||
					got.applied != exp_r.applied || got.saturated != exp_r.saturated) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: exp ax=%h ay=%h bx=%h by=%h app=%b sat=%b, ",
						"got ax=%h ay=%h bx=%h by=%h app=%b sat=%b",
						exp_r.vel_ax, exp_r.vel_ay, exp_r.vel_bx, exp_r.vel_by,
						exp_r.applied, exp_r.saturated, got.vel_ax, got.vel_ay,
						got.vel_bx, got.vel_by, got.applied, got.saturated);
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [10*WORD_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [4*WORD_W-1:0]  m_tdata;
	logic [1:0]           m_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REST_W-1:0]    cfg_data;

	collision_scoreboard sb;
	int  idle_cycles = 0;
	bit  hold_request = 0;
	bit  steady = 0;

	two_body_collision_response_2d i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [WORD_W-1:0] rand_word();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1: begin
				return $urandom;
			end
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: begin
				return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			end
		endcase
	endfunction

	function automatic logic [WORD_W-1:0] rand_mass();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return '0;
		if (r < 4) return $urandom;
		return $urandom_range(1, 32'h0040_0000);
	endfunction

	function automatic pair_t make_pair(logic t, logic [WORD_W-1:0] ma, logic [WORD_W-1:0] mb,
			logic [WORD_W-1:0] pax, logic [WORD_W-1:0] pay, logic [WORD_W-1:0] pbx,
			logic [WORD_W-1:0] pby, logic [WORD_W-1:0] vax, logic [WORD_W-1:0] vay,
			logic [WORD_W-1:0] vbx, logic [WORD_W-1:0] vby);
		pair_t p;
		p.touching = t; p.mass_a = ma; p.mass_b = mb;
		p.pos_ax = pax; p.pos_ay = pay; p.pos_bx = pbx; p.pos_by = pby;
		p.vel_ax = vax; p.vel_ay = vay; p.vel_bx = vbx; p.vel_by = vby;
		return p;
	endfunction

	function automatic pair_t rand_pair();
		pair_t p;
		p = make_pair($urandom_range(0, 9) != 0, rand_mass(), rand_mass(), rand_word(),
			rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
			rand_word());
		// Mostly make the bodies approach so the response path is exercised.
		if ($urandom_range(0, 3) != 0) begin
			p.vel_bx = p.vel_ax - $signed(p.pos_bx - p.pos_ax) / int'($urandom_range(1, 8));
			p.vel_by = p.vel_ay - $signed(p.pos_by - p.pos_ay) / int'($urandom_range(1, 8));
		end
		return p;
	endfunction

	task automatic send_pair(pair_t p);
		int gap;
		logic rdy;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= p.touching;
		s_tdata <= {p.vel_by, p.vel_bx, p.vel_ay, p.vel_ax, p.pos_by, p.pos_bx,
			p.pos_ay, p.pos_ax, p.mass_b, p.mass_a};
		do begin
			@(negedge clk);
			rdy = s_tready;
			@(posedge clk);
		end while (!rdy);
		idle_cycles = 0;
		sb.note_pair(p);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_restitution(logic [REST_W-1:0] value);
		logic rdy;
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 1'b0;
		sb.restitution = value;
	endtask

	task automatic random_phase();
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (i % 40 == 0)
				steady = ($urandom_range(0, 3) == 0);
			if (i == 60 && $urandom_range(0, 1) == 0)
				hold_request = 1;
			send_pair(rand_pair());
		end
	endtask

	// Receiver: random stalls, with an occasional long hold-off to back up the pipeline.
	initial begin
		logic             v, rdy;
		logic [4*WORD_W-1:0] d;
		logic [1:0]       u;
		int               hold;
		hold = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			v = m_tvalid;
			d = m_tdata;
			u = m_tuser;
			rdy = m_tready;
			@(posedge clk);
			if (v && rdy) begin
				idle_cycles = 0;
				sb.check_word(d, u);
			end
			if (hold_request) begin
				hold_request = 0;
				hold = 300;
			end
			if (hold > 0) begin
				hold--;
				m_tready <= 1'b0;
			end else if (steady) begin
				m_tready <= 1'b1;
			end else if ($urandom_range(0, 99) < 4) begin
				hold = $urandom_range(8, 30);
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(0, 99) < 70);
			end
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			idle_cycles++;
			if (idle_cycles > IDLE_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	initial begin
		logic [WORD_W-1:0] mx, mn, one;
		sb = new();
		mx = 32'h7FFF_FFFF;
		mn = 32'h8000_0000;
		one = 32'h0001_0000;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at the reset restitution.
		send_pair(make_pair(1'b0, one, one, 0, 0, one, 0, one, 0, -one, 0));
		send_pair(make_pair(1'b1, one, 0, 0, 0, one, 0, one, 0, -one, 0));
		send_pair(make_pair(1'b1, one, one, 0, 0, one, 0, -one, 0, one, 0));
		send_pair(make_pair(1'b1, one, one, one, one, one, one, one, 0, -one, 0));
		send_pair(make_pair(1'b1, 0, one, 0, 0, one, 0, one, 0, -one, 0));
		send_pair(make_pair(1'b1, one, one, 0, 0, one, 0, one, 0, -one, 0));
		send_pair(make_pair(1'b1, 2 * one, one, 0, 0, one, one, one, one, 0, -one));
		send_pair(make_pair(1'b1, one, 3 * one, 0, 0, -one, one, -one, one, one, 0));
		send_pair(make_pair(1'b1, mx, mx, mn, mn, mx, mx, mx, mx, mn, mn));
		send_pair(make_pair(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, mx, mx, mn, mn, mn, mn,
			mx, mx));
		send_pair(make_pair(1'b1, 1, 32'hFFFF_FFFF, 0, 0, 1, 0, mx, 0, mn, 0));
		send_pair(make_pair(1'b1, 32'hFFFF_FFFF, 1, 0, 0, 0, 1, 0, mx, 0, mn));
		send_pair(make_pair(1'b1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1));
		send_pair(make_pair(1'b1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_pair(make_pair(1'b1, one, one, mn, 0, mx, 0, mx, 0, mn, 0));
		send_pair(make_pair(1'b1, one, one, 0, mn, 0, mx, 0, mx, 0, mn));
		send_pair(make_pair(1'b1, one, one, 0, 0, 1, 1, 1, 1, 0, 0));
		random_phase();

		drain();
		write_restitution('0);
		send_pair(make_pair(1'b1, one, one, 0, 0, one, 0, one, 0, -one, 0));
		random_phase();
		drain();
		write_restitution(REST_ELASTIC);
		send_pair(make_pair(1'b1, one, one, 0, 0, one, 0, one, 0, -one, 0));
		random_phase();
		drain();
		write_restitution(REST_MAX);
		send_pair(make_pair(1'b1, mx, mx, mn, mn, mx, mx, mx, mx, mn, mn));
		random_phase();
		drain();
		write_restitution($urandom_range(0, REST_MAX));
		hold_request = 1;
		random_phase();
		drain();
		write_restitution(17'd32768);
		random_phase();

		drain();
		repeat (60) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

FILE: filelist.f
rtl/tbc_pkg.sv
rtl/tbc_div.sv
rtl/tbc_geom.sv
rtl/tbc_mix.sv
rtl/two_body_collision_response_2d.sv
tb/sv/tb_two_body_collision_response_2d.sv
